// File: src/atrd_pkg.sv
// Shared types, character codes and sizes for the AT response deframer.
package atrd_pkg;

   localparam int LINE_MAX_DEFAULT   = 256;
   localparam int HEADER_MAX_DEFAULT = 36;
   localparam int CLASS_QUEUE_DEPTH  = 4;
   localparam int RESULT_QUEUE_DEPTH = 4;

   localparam int BYTE_W     = 8;
   localparam int LINE_LEN_W = 9;
   localparam int LEN_W      = 16;
   localparam int COMMA_W    = 3;
   localparam int TAG_LEN    = 9;
   localparam int TAG_IDX_W  = 4;

   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2c;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [COMMA_W-1:0] LENGTH_COMMA = 3'd3;
   localparam logic [COMMA_W-1:0] COMMA_LIMIT  = 3'd4;

   typedef enum logic [2:0] {
      KIND_LINE_BYTE    = 3'd0,
      KIND_LINE_END     = 3'd1,
      KIND_REPORT_START = 3'd2,
      KIND_PAYLOAD_BYTE = 3'd3,
      KIND_HEADER_ERROR = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      MODE_HUNT    = 2'd0,
      MODE_LINE    = 2'd1,
      MODE_HEADER  = 2'd2,
      MODE_PAYLOAD = 2'd3
   } mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  byte_value;
      logic               is_cr;
      logic               is_lf;
      logic               is_comma;
      logic               is_digit;
      logic [3:0]         digit;
      logic [TAG_LEN-1:0] tag_hit;
   } class_type;

   typedef struct packed {
      kind_type              kind;
      logic [BYTE_W-1:0]     byte_value;
      logic [LINE_LEN_W-1:0] line_length;
      logic                  line_overflow;
      logic                  payload_last;
      logic                  last;
   } result_type;

   // Characters of the report prefix "+ZIPRECV:".
   function automatic logic [BYTE_W-1:0] tag_char(input logic [TAG_IDX_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      unique case (idx)
         4'd0:    c = 8'h2b;
         4'd1:    c = 8'h5a;
         4'd2:    c = 8'h49;
         4'd3:    c = 8'h50;
         4'd4:    c = 8'h52;
         4'd5:    c = 8'h45;
         4'd6:    c = 8'h43;
         4'd7:    c = 8'h56;
         4'd8:    c = 8'h3a;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// File: src/atrd_fifo.sv
// Small first-in first-out word queue with registered storage.
module atrd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = count_ff == CNT_FULL;
   assign empty   = count_ff == '0;
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/atrd_front.sv
// Front end: accepts received bytes, classifies them and queues the class words.
module atrd_front import atrd_pkg::*; #(
   parameter int CLASS_DEPTH = CLASS_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              q_pop,
   output logic              q_empty,
   output class_type         q_word
);

   class_type                  word;
   logic [$bits(class_type)-1:0] q_bits;

   always_comb begin
      word            = '0;
      word.byte_value = req_rx_byte;
      word.is_cr      = req_rx_byte == CHAR_CR;
      word.is_lf      = req_rx_byte == CHAR_LF;
      word.is_comma   = req_rx_byte == CHAR_COMMA;
      word.is_digit   = (req_rx_byte >= CHAR_ZERO) && (req_rx_byte <= CHAR_NINE);
      word.digit      = 4'(req_rx_byte - CHAR_ZERO);
      for (int i = 0; i < TAG_LEN; i++) begin
         word.tag_hit[i] = req_rx_byte == tag_char(TAG_IDX_W'(i));
      end
   end

   atrd_fifo #(
      .WIDTH ($bits(class_type)),
      .DEPTH (CLASS_DEPTH)
   ) u_class_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (word),
      .rd_en   (q_pop),
      .rd_data (q_bits),
      .full    (full),
      .empty   (q_empty)
   );

   assign q_word = class_type'(q_bits);

endmodule

// File: src/atrd_back.sv
// Back end: line, header and payload parser feeding the result queue.
module atrd_back import atrd_pkg::*; #(
   parameter int LINE_MAX     = LINE_MAX_DEFAULT,
   parameter int HEADER_MAX   = HEADER_MAX_DEFAULT,
   parameter int RESULT_DEPTH = RESULT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  class_type  q_word,
   input  logic       q_empty,
   output logic       q_pop,
   input  logic       pop,
   output logic       empty,
   output result_type rsp_word
);

   localparam int LC_W = $clog2(LINE_MAX + 1);
   localparam int HC_W = $clog2(HEADER_MAX + 1);
   localparam logic [LC_W-1:0] LC_MAX      = LC_W'(LINE_MAX);
   localparam logic [LC_W-1:0] LC_TAG_END  = LC_W'(TAG_LEN);
   localparam logic [LC_W-1:0] LC_TAG_LAST = LC_W'(TAG_LEN - 1);
   localparam logic [HC_W-1:0] HC_MAX      = HC_W'(HEADER_MAX);

   mode_type           mode_ff, mode_in;
   logic               cr_seen_ff, cr_seen_in;
   logic [LC_W-1:0]    line_count_ff, line_count_in;
   logic               line_over_ff, line_over_in;
   logic               prefix_match_ff, prefix_match_in;
   logic [COMMA_W-1:0] comma_count_ff, comma_count_in;
   logic [HC_W-1:0]    header_count_ff, header_count_in;
   logic [LEN_W-1:0]   report_length_ff, report_length_in;
   logic [LEN_W-1:0]   payload_count_ff, payload_count_in;
   logic               split_ff, split_in;

   logic               clear_line;
   logic               lc_in_tag, tag_ok, prefix_next, report_hit;
   logic               lc_full, lc_full1, over1, over2;
   logic [LC_W-1:0]    line_inc1, line_inc2;
   logic [COMMA_W-1:0] comma_inc;
   logic               comma_done;
   logic [HC_W-1:0]    header_inc;
   logic               hdr_full;
   logic [LEN_W+3:0]   len_times_ten;
   logic [LEN_W-1:0]   len_next, pc_inc;
   logic               pay_fin;
   logic               two_results, step, first_half, commit;

   result_type         res0, res1, res_wr;
   logic [1:0]         res_count;
   logic               res_push, res_full;
   logic [$bits(result_type)-1:0] rsp_bits;

   assign lc_in_tag   = line_count_ff < LC_TAG_END;
   assign tag_ok      = lc_in_tag ? q_word.tag_hit[line_count_ff[TAG_IDX_W-1:0]] : 1'b1;
   assign prefix_next = prefix_match_ff & tag_ok;
   assign report_hit  = (line_count_ff == LC_TAG_LAST) & prefix_next;
   assign lc_full     = line_count_ff == LC_MAX;
   assign line_inc1   = lc_full ? line_count_ff : line_count_ff + LC_W'(1);
   assign lc_full1    = line_inc1 == LC_MAX;
   assign line_inc2   = lc_full1 ? line_inc1 : line_inc1 + LC_W'(1);
   assign over1       = line_over_ff | lc_full;
   assign over2       = over1 | lc_full1;

   assign comma_inc     = comma_count_ff + COMMA_W'(1);
   assign comma_done    = comma_inc >= COMMA_LIMIT;
   assign header_inc    = header_count_ff + HC_W'(1);
   assign hdr_full      = header_count_ff >= HC_MAX;
   assign len_times_ten = ({4'b0000, report_length_ff} << 3)
                        + ({4'b0000, report_length_ff} << 1)
                        + {{LEN_W{1'b0}}, q_word.digit};
   assign len_next      = (len_times_ten[LEN_W+3:LEN_W] != 4'b0000) ? '1
                                                                     : len_times_ten[LEN_W-1:0];
   assign pc_inc        = payload_count_ff + LEN_W'(1);
   assign pay_fin       = pc_inc >= report_length_ff;

   // A held CR followed by an ordinary byte yields two results, written in turn.
   assign two_results = (mode_ff == MODE_LINE) & cr_seen_ff & ~q_word.is_lf & ~q_word.is_cr;
   assign step        = ~q_empty & ~res_full;
   assign first_half  = two_results & ~split_ff;
   assign commit      = step & ~first_half;
   assign q_pop       = commit;
   assign split_in    = step ? first_half : split_ff;
   assign res_push    = step & (res_count != 2'd0);
   assign res_wr      = split_ff ? res1 : res0;

   always_comb begin
      mode_in          = mode_ff;
      cr_seen_in       = cr_seen_ff;
      line_count_in    = line_count_ff;
      line_over_in     = line_over_ff;
      prefix_match_in  = prefix_match_ff;
      comma_count_in   = comma_count_ff;
      header_count_in  = header_count_ff;
      report_length_in = report_length_ff;
      payload_count_in = payload_count_ff;
      clear_line       = 1'b0;
      unique case (mode_ff)
         MODE_HUNT: begin
            if (cr_seen_ff && q_word.is_lf) begin
               mode_in    = MODE_LINE;
               cr_seen_in = 1'b0;
               clear_line = 1'b1;
            end else begin
               cr_seen_in = q_word.is_cr;
            end
         end
         MODE_LINE: begin
            if (cr_seen_ff) begin
               if (q_word.is_lf) begin
                  mode_in    = MODE_HUNT;
                  cr_seen_in = 1'b0;
                  clear_line = 1'b1;
               end else if (q_word.is_cr) begin
                  line_count_in   = line_inc1;
                  line_over_in    = over1;
                  prefix_match_in = prefix_match_ff & ~lc_in_tag;
               end else begin
                  cr_seen_in      = 1'b0;
                  line_count_in   = line_inc2;
                  line_over_in    = over2;
                  prefix_match_in = prefix_match_ff & ~lc_in_tag;
               end
            end else if (q_word.is_cr) begin
               cr_seen_in = 1'b1;
               if (line_count_ff == '0) begin
                  mode_in    = MODE_HUNT;
                  clear_line = 1'b1;
               end
            end else if (report_hit) begin
               mode_in          = MODE_HEADER;
               prefix_match_in  = prefix_next;
               comma_count_in   = '0;
               header_count_in  = '0;
               report_length_in = '0;
               payload_count_in = '0;
            end else begin
               line_count_in   = line_inc1;
               line_over_in    = over1;
               prefix_match_in = prefix_next;
            end
         end
         MODE_HEADER: begin
            if (hdr_full) begin
               mode_in    = MODE_HUNT;
               cr_seen_in = 1'b0;
               clear_line = 1'b1;
            end else begin
               header_count_in = header_inc;
               if (q_word.is_comma) begin
                  comma_count_in = comma_inc;
                  if (comma_done) begin
                     if (report_length_ff == '0) begin
                        mode_in    = MODE_LINE;
                        cr_seen_in = 1'b0;
                        clear_line = 1'b1;
                     end else begin
                        mode_in          = MODE_PAYLOAD;
                        payload_count_in = '0;
                     end
                  end
               end else if ((comma_count_ff == LENGTH_COMMA) && q_word.is_digit) begin
                  report_length_in = len_next;
               end
            end
         end
         MODE_PAYLOAD: begin
            payload_count_in = pc_inc;
            if (pay_fin) begin
               mode_in    = MODE_LINE;
               cr_seen_in = 1'b0;
               clear_line = 1'b1;
            end
         end
      endcase
      if (clear_line) begin
         line_count_in   = '0;
         line_over_in    = 1'b0;
         prefix_match_in = 1'b1;
      end
   end

   always_comb begin
      res0      = '0;
      res1      = '0;
      res_count = 2'd0;
      unique case (mode_ff)
         MODE_HUNT: begin
            res_count = 2'd0;
         end
         MODE_LINE: begin
            if (cr_seen_ff) begin
               if (q_word.is_lf) begin
                  res0.kind          = KIND_LINE_END;
                  res0.line_length   = LINE_LEN_W'(line_count_ff);
                  res0.line_overflow = line_over_ff;
                  res_count          = 2'd1;
               end else begin
                  res0.kind       = KIND_LINE_BYTE;
                  res0.byte_value = CHAR_CR;
                  res_count       = 2'd1;
                  if (!q_word.is_cr) begin
                     res1.kind       = KIND_LINE_BYTE;
                     res1.byte_value = q_word.byte_value;
                     res_count       = 2'd2;
                  end
               end
            end else if (q_word.is_cr) begin
               res_count = 2'd0;
            end else if (report_hit) begin
               res0.kind = KIND_REPORT_START;
               res_count = 2'd1;
            end else begin
               res0.kind       = KIND_LINE_BYTE;
               res0.byte_value = q_word.byte_value;
               res_count       = 2'd1;
            end
         end
         MODE_HEADER: begin
            if (hdr_full) begin
               res0.kind = KIND_HEADER_ERROR;
               res_count = 2'd1;
            end
         end
         MODE_PAYLOAD: begin
            res0.kind         = KIND_PAYLOAD_BYTE;
            res0.byte_value   = q_word.byte_value;
            res0.payload_last = pay_fin;
            res_count         = 2'd1;
         end
      endcase
      res0.last = res_count == 2'd1;
      res1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_HUNT;
         cr_seen_ff       <= 1'b0;
         line_count_ff    <= '0;
         line_over_ff     <= 1'b0;
         prefix_match_ff  <= 1'b1;
         comma_count_ff   <= '0;
         header_count_ff  <= '0;
         report_length_ff <= '0;
         payload_count_ff <= '0;
         split_ff         <= 1'b0;
      end else begin
         split_ff <= split_in;
         if (commit) begin
            mode_ff          <= mode_in;
            cr_seen_ff       <= cr_seen_in;
            line_count_ff    <= line_count_in;
            line_over_ff     <= line_over_in;
            prefix_match_ff  <= prefix_match_in;
            comma_count_ff   <= comma_count_in;
            header_count_ff  <= header_count_in;
            report_length_ff <= report_length_in;
            payload_count_ff <= payload_count_in;
         end
      end
   end

   atrd_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_wr),
      .rd_en   (pop),
      .rd_data (rsp_bits),
      .full    (res_full),
      .empty   (empty)
   );

   assign rsp_word = result_type'(rsp_bits);

endmodule

// File: src/at_response_deframer.sv
// Top level of the AT response deframer: byte classifier, class queue and parser.
//
// Channel  Direction  Handshake     Word
// req_     in         push / full   one received modem byte
// rsp_     out        pop / empty   one parse result
//
// Bytes are taken at one a cycle unless full; the parser retires one class word
// a cycle unless stalled. A held CR released ahead of an ordinary byte means two
// result writes for that byte, since the result queue takes one word a cycle.
// Four-word class and result queues let either side stall on its own.
// Reset is synchronous and empties both queues and clears the parse state.
module at_response_deframer import atrd_pkg::*; #(
   parameter int LINE_MAX     = LINE_MAX_DEFAULT,
   parameter int HEADER_MAX   = HEADER_MAX_DEFAULT,
   parameter int CLASS_DEPTH  = CLASS_QUEUE_DEPTH,
   parameter int RESULT_DEPTH = RESULT_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   output logic                  empty,
   input  logic                  pop,
   output logic [2:0]            rsp_kind,
   output logic [BYTE_W-1:0]     rsp_byte_value,
   output logic [LINE_LEN_W-1:0] rsp_line_length,
   output logic                  rsp_line_overflow,
   output logic                  rsp_payload_last,
   output logic                  rsp_last
);

   class_type  q_word;
   logic       q_empty, q_pop;
   result_type rsp_word;

   atrd_front #(
      .CLASS_DEPTH (CLASS_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_rx_byte (req_rx_byte),
      .q_pop       (q_pop),
      .q_empty     (q_empty),
      .q_word      (q_word)
   );

   atrd_back #(
      .LINE_MAX     (LINE_MAX),
      .HEADER_MAX   (HEADER_MAX),
      .RESULT_DEPTH (RESULT_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_word   (q_word),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_word (rsp_word)
   );

   assign rsp_kind          = rsp_word.kind;
   assign rsp_byte_value    = rsp_word.byte_value;
   assign rsp_line_length   = rsp_word.line_length;
   assign rsp_line_overflow = rsp_word.line_overflow;
   assign rsp_payload_last  = rsp_word.payload_last;
   assign rsp_last          = rsp_word.last;

endmodule

// File: src/atrd_checker.sv
// Port-level assertions for the AT response deframer and their binding.
module atrd_checker import atrd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  push,
   input logic                  full,
   input logic [BYTE_W-1:0]     req_rx_byte,
   input logic                  empty,
   input logic                  pop,
   input logic [2:0]            rsp_kind,
   input logic [BYTE_W-1:0]     rsp_byte_value,
   input logic [LINE_LEN_W-1:0] rsp_line_length,
   input logic                  rsp_line_overflow,
   input logic                  rsp_payload_last,
   input logic                  rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_byte_only_on_data: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind != KIND_LINE_BYTE && rsp_kind != KIND_PAYLOAD_BYTE)
      |-> (rsp_byte_value == '0))
      else $error("byte value set on a word that carries no byte");

   a_flags_match_kind: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((!rsp_line_overflow || rsp_kind == KIND_LINE_END)
                  && (!rsp_payload_last || rsp_kind == KIND_PAYLOAD_BYTE)))
      else $error("flag set on a word of the wrong kind");

   a_single_result_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind != KIND_LINE_BYTE) |-> rsp_last)
      else $error("word that is always alone for its byte not marked last");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_kind) && $stable(rsp_byte_value)
                            && $stable(rsp_last)))
      else $error("stalled result word changed");

endmodule

bind at_response_deframer atrd_checker u_atrd_checker (.*);
